>>> rtl/chd_pkg.sv
// Shared types and constants of the canonical Huffman decoder.
package chd_pkg;
    localparam int MaxCodeLenDef  = 16;
    localparam int SymbolDepthDef = 256;

    localparam logic [1:0] REQ_COUNT  = 2'd0;
    localparam logic [1:0] REQ_SYMBOL = 2'd1;
    localparam logic [1:0] REQ_BUILD  = 2'd2;
    localparam logic [1:0] REQ_DATA   = 2'd3;

    localparam logic [2:0] ST_SYMBOL   = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_TABLE_OK = 3'd2;
    localparam logic [2:0] ST_TOO_MANY = 3'd3;
    localparam logic [2:0] ST_OVERFULL = 3'd4;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] symbol;
        logic [4:0] code_length;
        logic       last;
    } chd_result_t;
endpackage

>>> rtl/chd_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module chd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

>>> rtl/canonical_huffman_decoder_unit.sv
// Top level of the canonical Huffman decoder: sequencer, shared adder/compare, stores.
//
// Usage: items arrive on the s_ channel (valid/ready); s_req_type selects load count,
// load symbol, build table or data byte. Results leave on the m_ channel, one beat
// per result, m_last marking the final beat caused by an item.
// A build walks the code lengths up to three times with one shared adder/compare
// before its single result beat is offered (error builds stop earlier).
// A data byte is shifted in bit by bit, with a symbol-RAM read for each decoded
// or invalid code, and waits for each result beat to be handed off. A result is
// held back until the next code or the end of the byte shows whether it is the
// last one. Bytes that arrive before a valid table are dropped.
// s_ready is high only in the idle state; one item is worked at a time.
// When the receiver stalls, the sequencer holds with the result in the output
// register until the beat is taken; no bits are lost.
// Reset (aresetn low, synchronous) clears counts, the decode stores (max code
// minus one, offsets zero), table valid and the pending code. The symbol store
// is not cleared; entries must be written before they are decoded.
module canonical_huffman_decoder_unit
    import chd_pkg::*;
#(
    parameter int MAX_CODE_LEN = MaxCodeLenDef,
    parameter int SYMBOL_DEPTH = SymbolDepthDef
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_req_type,
    input  logic [4:0] s_length_index,
    input  logic [7:0] s_count_value,
    input  logic [7:0] s_symbol_position,
    input  logic [7:0] s_symbol_value,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic [7:0] m_symbol,
    output logic [4:0] m_code_length,
    output logic       m_last
);
    localparam int LW = $clog2(MAX_CODE_LEN);   // length index width
    localparam int AW = $clog2(SYMBOL_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_SUM, S_CHK, S_FILL, S_BRES, S_BIT, S_RD, S_SYM, S_OUT
    } state_t;

    state_t state_reg;
    logic [7:0]  cnt_reg [MAX_CODE_LEN];
    logic [16:0] maxc_reg [MAX_CODE_LEN];
    logic [17:0] voff_reg [MAX_CODE_LEN];
    logic        valid_tab_reg;
    logic [16:0] pcode_reg;
    logic [4:0]  plen_reg;
    logic [LW-1:0] li_reg;
    logic [17:0] acc_reg;       // running total or code
    logic [8:0]  pos_reg;
    logic [7:0]  byte_reg;
    logic [3:0]  bits_reg;      // bits left in byte
    logic [17:0] idx_reg;
    logic [2:0]  hit_st_reg;    // status of the code just found
    logic [4:0]  hit_len_reg;
    chd_result_t held_reg;      // result waiting to learn whether it is the last
    logic        hold_reg;
    chd_result_t res_reg;
    logic        mv_reg;

    // shared adder operands
    logic [17:0] add_a, add_b, add_s;
    logic [7:0]  cur_cnt;
    logic [16:0] ncode;
    logic [4:0]  nlen;
    logic [LW-1:0] nli;
    logic        is_last_len;
    logic [AW-1:0] ram_wa;
    logic [7:0]  ram_q;
    logic        ram_we;
    logic [7:0]  hit_sym;
    chd_result_t hit_res;

    assign cur_cnt     = cnt_reg[li_reg];
    assign is_last_len = (li_reg == LW'(MAX_CODE_LEN - 1));
    assign ncode       = {pcode_reg[15:0], byte_reg[7]};
    assign nlen        = plen_reg + 5'd1;
    assign nli         = plen_reg[LW-1:0];

    always_comb begin
        add_a = acc_reg;
        add_b = {10'd0, cur_cnt};
        if (state_reg == S_BIT) begin
            add_a = {1'b0, ncode};
            add_b = voff_reg[nli];
        end
        add_s = add_a + add_b;
    end

    assign ram_we = s_valid && s_ready && (s_req_type == REQ_SYMBOL)
                    && (9'(s_symbol_position) < 9'(SYMBOL_DEPTH));
    assign ram_wa = s_symbol_position[AW-1:0];

    chd_ram #(.WIDTH(8), .DEPTH(SYMBOL_DEPTH)) u_sym (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_wa),
        .wr_data(s_symbol_value),
        .rd_addr(idx_reg[AW-1:0]),
        .rd_data(ram_q)
    );

    // invalid codes and out-of-range indexes give symbol zero
    assign hit_sym = (hit_st_reg == ST_SYMBOL && idx_reg < 18'(SYMBOL_DEPTH)) ? ram_q : 8'd0;
    assign hit_res = {hit_st_reg, hit_sym, hit_len_reg, 1'b0};

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = mv_reg;
    assign m_status      = res_reg.status;
    assign m_symbol      = res_reg.symbol;
    assign m_code_length = res_reg.code_length;
    assign m_last        = res_reg.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            valid_tab_reg <= 1'b0;
            pcode_reg     <= '0;
            plen_reg      <= '0;
            mv_reg        <= 1'b0;
            hold_reg      <= 1'b0;
            for (int i = 0; i < MAX_CODE_LEN; i++) begin
                cnt_reg[i]  <= '0;
                maxc_reg[i] <= '1;
                voff_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        case (s_req_type)
                            REQ_COUNT: begin
                                if (s_length_index >= 5'd1
                                    && 6'(s_length_index) <= 6'(MAX_CODE_LEN)) begin
                                    cnt_reg[LW'(s_length_index - 5'd1)] <= s_count_value;
                                end
                            end
                            REQ_BUILD: begin
                                pcode_reg <= '0;
                                plen_reg  <= '0;
                                li_reg    <= '0;
                                acc_reg   <= '0;
                                state_reg <= S_SUM;
                            end
                            REQ_DATA: begin
                                if (valid_tab_reg) begin
                                    byte_reg  <= s_data_byte;
                                    bits_reg  <= 4'd8;
                                    state_reg <= S_BIT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SUM: begin
                    acc_reg <= add_s;
                    li_reg  <= li_reg + LW'(1);
                    if (is_last_len) begin
                        li_reg <= '0;
                        if (add_s > 18'(SYMBOL_DEPTH)) begin
                            res_reg       <= '{ST_TOO_MANY, 8'd0, 5'd0, 1'b1};
                            valid_tab_reg <= 1'b0;
                            state_reg     <= S_BRES;
                        end else begin
                            acc_reg   <= '0;
                            state_reg <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    // code + count must stay below 2^len
                    if ((add_s >> (5'(li_reg) + 5'd1)) != 18'd0) begin
                        res_reg       <= '{ST_OVERFULL, 8'd0, 5'd0, 1'b1};
                        valid_tab_reg <= 1'b0;
                        state_reg     <= S_BRES;
                    end else if (is_last_len) begin
                        li_reg    <= '0;
                        acc_reg   <= '0;
                        pos_reg   <= '0;
                        state_reg <= S_FILL;
                    end else begin
                        acc_reg <= {add_s[16:0], 1'b0};
                        li_reg  <= li_reg + LW'(1);
                    end
                end
                S_FILL: begin
                    if (cur_cnt != 8'd0) begin
                        voff_reg[li_reg] <= 18'({9'd0, pos_reg}) - acc_reg;
                        maxc_reg[li_reg] <= add_s[16:0] - 17'd1;
                        pos_reg          <= pos_reg + 9'(cur_cnt);
                    end else begin
                        voff_reg[li_reg] <= '0;
                        maxc_reg[li_reg] <= '1;
                    end
                    acc_reg <= {add_s[16:0], 1'b0};
                    li_reg  <= li_reg + LW'(1);
                    if (is_last_len) begin
                        res_reg       <= '{ST_TABLE_OK, 8'd0, 5'd0, 1'b1};
                        valid_tab_reg <= 1'b1;
                        state_reg     <= S_BRES;
                    end
                end
                S_BRES: begin
                    if (!mv_reg) begin
                        mv_reg <= 1'b1;
                    end else if (m_ready) begin
                        mv_reg    <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                S_BIT: begin
                    byte_reg <= {byte_reg[6:0], 1'b0};
                    bits_reg <= bits_reg - 4'd1;
                    if (6'(nlen) > 6'(MAX_CODE_LEN)) begin
                        hit_st_reg  <= ST_INVALID;
                        hit_len_reg <= nlen;
                        pcode_reg   <= '0;
                        plen_reg    <= '0;
                        state_reg   <= S_RD;
                    end else if (maxc_reg[nli] != '1 && ncode <= maxc_reg[nli]) begin
                        idx_reg     <= add_s;
                        hit_st_reg  <= ST_SYMBOL;
                        hit_len_reg <= nlen;
                        pcode_reg   <= '0;
                        plen_reg    <= '0;
                        state_reg   <= S_RD;
                    end else begin
                        pcode_reg <= ncode;
                        plen_reg  <= nlen;
                        if (bits_reg == 4'd1) begin
                            // byte done: the held result is the last one
                            if (hold_reg) begin
                                res_reg   <= '{held_reg.status, held_reg.symbol,
                                               held_reg.code_length, 1'b1};
                                hold_reg  <= 1'b0;
                                mv_reg    <= 1'b1;
                                state_reg <= S_OUT;
                            end else begin
                                state_reg <= S_IDLE;
                            end
                        end
                    end
                end
                S_RD: state_reg <= S_SYM;
                S_SYM: begin
                    if (hold_reg) begin
                        // a newer result exists, so the held one is not the last
                        res_reg   <= held_reg;
                        held_reg  <= hit_res;
                        mv_reg    <= 1'b1;
                        state_reg <= S_OUT;
                    end else if (bits_reg == 4'd0) begin
                        res_reg   <= '{hit_res.status, hit_res.symbol,
                                       hit_res.code_length, 1'b1};
                        mv_reg    <= 1'b1;
                        state_reg <= S_OUT;
                    end else begin
                        held_reg  <= hit_res;
                        hold_reg  <= 1'b1;
                        state_reg <= S_BIT;
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        if (bits_reg != 4'd0) begin
                            mv_reg    <= 1'b0;
                            state_reg <= S_BIT;
                        end else if (hold_reg) begin
                            res_reg  <= '{held_reg.status, held_reg.symbol,
                                          held_reg.code_length, 1'b1};
                            hold_reg <= 1'b0;
                        end else begin
                            mv_reg    <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
